[rtl/tmfl_pkg.sv]
// ----------------------------------------------------------------------------
// tmfl_pkg
// Shared types and codes for the tagged message field lookup core.
// ----------------------------------------------------------------------------
package tmfl_pkg;

  localparam int WordW  = 32;
  localparam int StartW = 9;
  localparam int BytesW = 11;
  localparam int NwordW = 9;
  localparam int NtagW  = 9;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [WordW-1:0]  tag;
    logic [StartW-1:0] start_word;
    logic [BytesW-1:0] nbytes;
  } lookup_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [StartW-1:0] start_word;
    logic [BytesW-1:0] nbytes;
  } lookup_res_t;

endpackage

[rtl/tagged_message_field_lookup_core.sv]
// ----------------------------------------------------------------------------
// tagged_message_field_lookup_core
// Loads a tagged message word by word and looks up the value slice of a tag.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   opcode, load_word, search_tag,
//                                                 window_start_word, window_bytes
//   out      output     out_valid_o / out_ready_i status, value_start_word,
//                                                 value_bytes
//
// Clear and append give no item on out.
// A lookup reads the count, then the tags in turn until one matches, then its
// offset and end (the last tag's end comes from the window size), then checks
// the slice in S_CALC and S_CHK. A lookup rejected on its window reads no word.
// in_ready_o is low while a lookup runs or its result waits for the out register.
// Reset (rst_ni low) empties the message; no clearing pass is needed.
// ----------------------------------------------------------------------------
module tagged_message_field_lookup_core import tmfl_pkg::*; #(
  parameter int STORE_WORDS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [WordW-1:0]  load_word_i,
  input  logic [WordW-1:0]  search_tag_i,
  input  logic [StartW-1:0] window_start_word_i,
  input  logic [BytesW-1:0] window_bytes_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [StartW-1:0] value_start_word_o,
  output logic [BytesW-1:0] value_bytes_o
);

  localparam int CntW  = $clog2(STORE_WORDS + 1);
  localparam int AddrW = $clog2(STORE_WORDS);

  logic [CntW-1:0]  word_count_q;
  logic             in_fire;
  logic             store_we;
  logic             seq_start;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic [WordW-1:0] rd_data;
  logic             seq_idle;
  logic             res_valid;
  logic             res_take;
  lookup_req_t      req;
  lookup_res_t      res;
  logic             out_valid_q;
  lookup_res_t      out_q;

  assign in_fire   = in_valid_i && in_ready_o;
  assign store_we  = in_fire && (opcode_i == OP_APPEND) &&
                     (word_count_q < CntW'(STORE_WORDS));
  assign seq_start = in_fire && (opcode_i == OP_LOOKUP);
  assign req       = '{tag: search_tag_i, start_word: window_start_word_i,
                       nbytes: window_bytes_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
    end else if (in_fire && (opcode_i == OP_CLEAR)) begin
      word_count_q <= '0;
    end else if (store_we) begin
      word_count_q <= word_count_q + CntW'(1);
    end
  end

  tmfl_store #(
    .StoreWords(STORE_WORDS),
    .AddrW     (AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(word_count_q[AddrW-1:0]),
    .wdata_i(load_word_i),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  tmfl_seq #(
    .CntW (CntW),
    .AddrW(AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (seq_start),
    .req_i       (req),
    .word_count_i(word_count_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .idle_o      (seq_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign in_ready_o = seq_idle;
  assign res_take   = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_q.status;
  assign value_start_word_o = out_q.start_word;
  assign value_bytes_o      = out_q.nbytes;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_count_q <= CntW'(STORE_WORDS))
    else $error("word count past store depth");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_start |=> !in_ready_o)
    else $error("ready while lookup runs");

  a_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_FOUND) |->
      (value_start_word_o == '0) && (value_bytes_o == '0))
    else $error("nonzero slice on failed lookup");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_FOUND) || (status_o == ST_MALFORMED) ||
      (status_o == ST_NOT_FOUND))
    else $error("bad status code");
`endif

endmodule

[rtl/tmfl_store.sv]
// ----------------------------------------------------------------------------
// tmfl_store
// Message word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmfl_store import tmfl_pkg::*; #(
  parameter int StoreWords = 256,
  parameter int AddrW      = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WordW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WordW-1:0] rdata_o
);

  logic [WordW-1:0] mem_q [StoreWords];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tmfl_seq.sv]
// ----------------------------------------------------------------------------
// tmfl_seq
// Lookup sequencer: reads count, tags, offsets and ends through the store read
// port and checks the value slice in two states, S_CALC and S_CHK.
// ----------------------------------------------------------------------------
module tmfl_seq import tmfl_pkg::*; #(
  parameter int CntW  = 9,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  lookup_req_t      req_i,
  input  logic [CntW-1:0]  word_count_i,
  output logic             rd_en_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [WordW-1:0] rd_data_i,
  output logic             idle_o,
  output logic             res_valid_o,
  output lookup_res_t      res_o,
  input  logic             res_take_i
);

  localparam int WinW = ((CntW > StartW) ? CntW : StartW) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CNT, S_TAG, S_OFF, S_END, S_CALC, S_CHK, S_DONE
  } state_e;

  state_e            state_q;
  lookup_req_t       req_q;
  logic [NtagW-1:0]  ntags_q;
  logic [NtagW-1:0]  i_q;
  logic [WordW-1:0]  off_q;
  logic [WordW-1:0]  end_q;
  logic [WordW-1:0]  sz_q;
  logic [WordW-1:0]  woff_q;
  lookup_res_t       res_q;

  logic [NwordW-1:0] nwords_in;
  logic [NwordW-1:0] nwords_q;
  logic              win_ok;
  logic              cnt_zero;
  logic              cnt_big;
  logic              tag_hit;
  logic              last_tag;
  logic [NwordW:0]   next_tag_idx;
  logic              next_in_win;
  logic [NwordW:0]   rd_idx;
  logic [StartW-1:0] rd_base;
  logic [WinW-1:0]   rd_sum;
  logic [WordW-1:0]  off_val;
  logic [WordW+2:0]  span_end;

  assign nwords_in = req_i.nbytes[BytesW-1:2];
  assign nwords_q  = req_q.nbytes[BytesW-1:2];

  assign win_ok = (req_i.nbytes[1:0] == 2'b00) && (nwords_in != '0) &&
                  ((WinW'(req_i.start_word) + WinW'(nwords_in)) <= WinW'(word_count_i));

  assign cnt_zero     = (rd_data_i == '0);
  assign cnt_big      = (rd_data_i >= WordW'(nwords_q));
  assign tag_hit      = (rd_data_i == req_q.tag);
  assign last_tag     = ((i_q + NtagW'(1)) == ntags_q);
  assign next_tag_idx = (NwordW+1)'(i_q) + (NwordW+1)'(ntags_q) + (NwordW+1)'(1);
  assign next_in_win  = (next_tag_idx < (NwordW+1)'(nwords_q));
  assign off_val      = (i_q == '0) ? '0 : rd_data_i;
  assign span_end     = (WordW+3)'({woff_q, 2'b00}) + (WordW+3)'(sz_q);

  always_comb begin
    rd_en_o = 1'b0;
    rd_idx  = '0;
    unique case (state_q)
      S_IDLE: begin
        rd_en_o = start_i && win_ok;
      end
      S_CNT: begin
        rd_en_o = !cnt_zero && !cnt_big;
        rd_idx  = (NwordW+1)'(rd_data_i[NtagW-1:0]);
      end
      S_TAG: begin
        if (tag_hit) begin
          rd_en_o = 1'b1;
          rd_idx  = (NwordW+1)'(i_q);
        end else begin
          rd_en_o = !last_tag && next_in_win;
          rd_idx  = next_tag_idx;
        end
      end
      S_OFF: begin
        rd_en_o = !last_tag;
        rd_idx  = (NwordW+1)'(i_q) + (NwordW+1)'(1);
      end
      default: begin
        rd_en_o = 1'b0;
      end
    endcase
  end

  assign rd_base   = (state_q == S_IDLE) ? req_i.start_word : req_q.start_word;
  assign rd_sum    = WinW'(rd_base) + WinW'(rd_idx);
  assign rd_addr_o = rd_sum[AddrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      ntags_q <= '0;
      i_q     <= '0;
      off_q   <= '0;
      end_q   <= '0;
      sz_q    <= '0;
      woff_q  <= '0;
      res_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            req_q <= req_i;
            if (win_ok) begin
              state_q <= S_CNT;
            end else begin
              res_q   <= '{status: ST_MALFORMED, start_word: '0, nbytes: '0};
              state_q <= S_DONE;
            end
          end
        end
        S_CNT: begin
          ntags_q <= rd_data_i[NtagW-1:0];
          i_q     <= '0;
          if (cnt_zero) begin
            res_q   <= '{status: ST_NOT_FOUND, start_word: '0, nbytes: '0};
            state_q <= S_DONE;
          end else if (cnt_big) begin
            res_q   <= '{status: ST_MALFORMED, start_word: '0, nbytes: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_TAG;
          end
        end
        S_TAG: begin
          if (tag_hit) begin
            state_q <= S_OFF;
          end else if (last_tag) begin
            res_q   <= '{status: ST_NOT_FOUND, start_word: '0, nbytes: '0};
            state_q <= S_DONE;
          end else if (!next_in_win) begin
            res_q   <= '{status: ST_MALFORMED, start_word: '0, nbytes: '0};
            state_q <= S_DONE;
          end else begin
            i_q <= i_q + NtagW'(1);
          end
        end
        S_OFF: begin
          off_q <= off_val;
          if (last_tag) begin
            end_q   <= WordW'(req_q.nbytes) - WordW'({ntags_q, 3'b000});
            state_q <= S_CALC;
          end else begin
            state_q <= S_END;
          end
        end
        S_END: begin
          end_q   <= rd_data_i;
          state_q <= S_CALC;
        end
        S_CALC: begin
          sz_q    <= end_q - off_q;
          woff_q  <= WordW'({ntags_q, 1'b0}) + WordW'(off_q[WordW-1:2]);
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (span_end > (WordW+3)'(req_q.nbytes)) begin
            res_q <= '{status: ST_MALFORMED, start_word: '0, nbytes: '0};
          end else begin
            res_q <= '{status:     ST_FOUND,
                       start_word: req_q.start_word + woff_q[StartW-1:0],
                       nbytes:     sz_q[BytesW-1:0]};
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule
